FILE: rtl/core/ptts_pkg.sv
`default_nettype none

package ptts_pkg;

    localparam int FRAME_SIZE = 256;
    localparam int HALF_FRAME = FRAME_SIZE / 2;

    localparam logic [1:0] OP_FACE = 2'd0;
    localparam logic [1:0] OP_EOF  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [5:0] CMD_NONE  = 6'd0;
    localparam logic [5:0] CMD_DOWN  = 6'd1;
    localparam logic [5:0] CMD_UP    = 6'd2;
    localparam logic [5:0] CMD_LEFT  = 6'd4;
    localparam logic [5:0] CMD_RIGHT = 6'd8;
    localparam logic [5:0] CMD_STOP  = 6'd32;

    localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
    localparam logic [1:0] REG_STOP_WAIT = 2'd1;
    localparam logic [1:0] REG_MOVE_WAIT = 2'd2;

    localparam logic [15:0] DEAD_ZONE_RESET = 16'd625;
    localparam logic [7:0]  STOP_WAIT_RESET = 8'd20;
    localparam logic [7:0]  MOVE_WAIT_RESET = 8'd30;

    localparam logic [17:0] DIST_NONE = 18'h3FFFF;

    typedef struct packed {
        logic [15:0] dead_zone_squared;
        logic [7:0]  stop_wait;
        logic [7:0]  move_wait;
    } t_cfg;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] face_x;
        logic [7:0] face_y;
        logic [8:0] face_width;
        logic [8:0] face_height;
    } t_item;

    typedef struct packed {
        logic        [5:0] command;
        logic        [7:0] wait_units;
        logic signed [8:0] remaining_x;
        logic signed [8:0] remaining_y;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/pan_tilt_target_stepper.sv
// Channel   Direction  Transaction
// s_axis    in         one item: tuser = opcode, tdata = face rectangle
// m_axis    out        one command per tick item
// i_cfg_*   in         register write, no handshake
//
// One item is accepted every cycle unless the input is stalled. Each item waits in the input register,
// where it is applied to the tracking state; a tick loads the result register.
// A tick thus passes through the input register and then the result register, which
// drives output valid.
// Reset is synchronous and clears the tracking state and both valid flags.
// A stalled output holds a tick in the input register, which then stalls the input;
// while no tick waits there, face and end-of-frame items keep flowing.
`default_nettype none

module pan_tilt_target_stepper
    import ptts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: face_x[7:0], face_y[15:8], face_width[24:16], face_height[33:25], zeros
    input  wire logic [39:0] s_axis_tdata,
    // tuser: opcode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: command[5:0], wait_units[13:6], remaining_x[22:14], remaining_y[31:23]
    output logic [31:0]      m_axis_tdata
);

    t_cfg    r_cfg;
    t_item   r_in_item;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result step_result;
    logic    advance, is_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_zone_squared <= DEAD_ZONE_RESET;
            r_cfg.stop_wait         <= STOP_WAIT_RESET;
            r_cfg.move_wait         <= MOVE_WAIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEAD_ZONE: r_cfg.dead_zone_squared <= i_cfg_data;
                REG_STOP_WAIT: r_cfg.stop_wait         <= i_cfg_data[7:0];
                REG_MOVE_WAIT: r_cfg.move_wait         <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign is_tick       = (r_in_item.opcode == OP_TICK);
    assign advance       = r_in_valid && (!is_tick || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.opcode      <= s_axis_tuser;
            r_in_item.face_x      <= s_axis_tdata[7:0];
            r_in_item.face_y      <= s_axis_tdata[15:8];
            r_in_item.face_width  <= s_axis_tdata[24:16];
            r_in_item.face_height <= s_axis_tdata[33:25];
        end
    end

    ptts_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_tick) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_tick) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.remaining_y, r_out.remaining_x,
                            r_out.wait_units, r_out.command};

endmodule

`default_nettype wire

FILE: rtl/core/ptts_datapath.sv
`default_nettype none

module ptts_datapath
    import ptts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output t_result      o_result
);

    function automatic logic [17:0] sq_mag(input logic signed [8:0] v);
        logic [8:0] m;
        m = v[8] ? (~v + 9'd1) : v;
        return {9'd0, m} * {9'd0, m};
    endfunction

    function automatic logic signed [8:0] face_offset(input logic [7:0] edge_pos,
                                                      input logic [8:0] extent);
        logic        [9:0]  center;
        logic signed [10:0] raw;
        center = {2'b00, edge_pos} + {2'b00, extent[8:1]};
        raw    = $signed({1'b0, center}) - 11'(HALF_FRAME);
        if (raw > 11'sd255) begin
            return 9'sd255;
        end else if (raw < -11'sd256) begin
            return -9'sd256;
        end else begin
            return raw[8:0];
        end
    endfunction

    logic signed [8:0] r_target_x, r_target_y;
    logic signed [8:0] r_best_x, r_best_y;
    logic        [17:0] r_best_distance;
    logic               r_face_seen;

    logic signed [8:0] n_target_x, n_target_y;
    logic signed [8:0] face_dx, face_dy;
    logic        [17:0] face_d2, target_len2;
    logic        [8:0]  mag_x, mag_y;
    logic        [5:0]  cmd;
    logic        [7:0]  wait_val;
    logic               keep_face, take_best;

    always_comb begin
        face_dx   = face_offset(i_item.face_x, i_item.face_width);
        face_dy   = face_offset(i_item.face_y, i_item.face_height);
        face_d2   = sq_mag(face_dx) + sq_mag(face_dy);
        keep_face = !r_face_seen || (face_d2 < r_best_distance);
        take_best = r_face_seen && (r_best_distance >= {2'b00, i_cfg.dead_zone_squared});

        mag_x       = r_target_x[8] ? (~r_target_x + 9'd1) : r_target_x;
        mag_y       = r_target_y[8] ? (~r_target_y + 9'd1) : r_target_y;
        target_len2 = sq_mag(r_target_x) + sq_mag(r_target_y);

        n_target_x = r_target_x;
        n_target_y = r_target_y;
        cmd        = CMD_NONE;
        wait_val   = i_cfg.move_wait;
        if (target_len2 < {2'b00, i_cfg.dead_zone_squared}) begin
            cmd      = CMD_STOP;
            wait_val = i_cfg.stop_wait;
        end else if (mag_x > mag_y) begin
            if (r_target_x < 0) begin
                cmd        = CMD_LEFT;
                n_target_x = r_target_x + 9'sd1;
            end else if (r_target_x > 0) begin
                cmd        = CMD_RIGHT;
                n_target_x = r_target_x - 9'sd1;
            end
        end else begin
            if (r_target_y > 0) begin
                cmd        = CMD_DOWN;
                n_target_y = r_target_y - 9'sd1;
            end else if (r_target_y < 0) begin
                cmd        = CMD_UP;
                n_target_y = r_target_y + 9'sd1;
            end
        end

        o_result.command     = cmd;
        o_result.wait_units  = wait_val;
        o_result.remaining_x = n_target_x;
        o_result.remaining_y = n_target_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x      <= '0;
            r_target_y      <= '0;
            r_best_x        <= '0;
            r_best_y        <= '0;
            r_best_distance <= DIST_NONE;
            r_face_seen     <= 1'b0;
        end else if (i_en) begin
            case (i_item.opcode)
                OP_FACE: begin
                    if (keep_face) begin
                        r_best_x        <= face_dx;
                        r_best_y        <= face_dy;
                        r_best_distance <= face_d2;
                        r_face_seen     <= 1'b1;
                    end
                end
                OP_EOF: begin
                    if (take_best) begin
                        r_target_x <= r_best_x;
                        r_target_y <= r_best_y;
                    end
                    r_best_distance <= DIST_NONE;
                    r_face_seen     <= 1'b0;
                end
                OP_TICK: begin
                    r_target_x <= n_target_x;
                    r_target_y <= n_target_y;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ptts_checker.sv
`default_nettype none

module ptts_checker
    import ptts_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    logic [5:0] out_cmd;
    logic [8:0] out_rx, out_ry;

    assign out_cmd = m_axis_tdata[5:0];
    assign out_rx  = m_axis_tdata[22:14];
    assign out_ry  = m_axis_tdata[31:23];

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transaction changed");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register empty");

    a_legal_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_cmd == CMD_NONE || out_cmd == CMD_DOWN || out_cmd == CMD_UP
                           || out_cmd == CMD_LEFT || out_cmd == CMD_RIGHT
                           || out_cmd == CMD_STOP))
        else $error("illegal command code");

    a_none_means_centered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && out_cmd == CMD_NONE |-> out_rx == 9'd0 && out_ry == 9'd0)
        else $error("no-move command with nonzero target");

endmodule

bind pan_tilt_target_stepper ptts_checker u_ptts_checker (.*);

`default_nettype wire

FILE: sim/pan_tilt_target_stepper_tb.sv
`default_nettype none

module pan_tilt_target_stepper_tb;
    import ptts_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: face_x[7:0], face_y[15:8], face_width[24:16], face_height[33:25], zeros
    logic [39:0] s_axis_tdata = '0;
    // tuser: opcode[1:0]
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: command[5:0], wait_units[13:6], remaining_x[22:14], remaining_y[31:23]
    logic [31:0] m_axis_tdata;

    pan_tilt_target_stepper DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Tracking state and register copies kept by the testbench.
    logic [15:0]       dead_zone = DEAD_ZONE_RESET;
    logic [7:0]        stop_units = STOP_WAIT_RESET;
    logic [7:0]        move_units = MOVE_WAIT_RESET;
    logic signed [8:0] target_x = '0;
    logic signed [8:0] target_y = '0;
    logic signed [8:0] best_x = '0;
    logic signed [8:0] best_y = '0;
    logic [17:0]       best_distance = DIST_NONE;
    logic              face_seen = 1'b0;

    t_result expected_commands[$];
    int      failures = 0;
    bit      quiet = 1'b0;

    function automatic int clamp_offset(int v);
        if (v < -256) return -256;
        if (v > 255) return 255;
        return v;
    endfunction

    task automatic track_item(t_item it);
        int dx;
        int dy;
        int tx;
        int ty;
        int len2;
        t_result r;
        case (it.opcode)
            OP_FACE: begin
                dx = clamp_offset(int'(it.face_x) + int'(it.face_width) / 2 - HALF_FRAME);
                dy = clamp_offset(int'(it.face_y) + int'(it.face_height) / 2 - HALF_FRAME);
                if (!face_seen || (dx * dx + dy * dy) < int'(best_distance)) begin
                    best_x = dx[8:0];
                    best_y = dy[8:0];
                    best_distance = 18'(dx * dx + dy * dy);
                    face_seen = 1'b1;
                end
            end
            OP_EOF: begin
                if (face_seen && best_distance >= dead_zone) begin
                    target_x = best_x;
                    target_y = best_y;
                end
                best_distance = DIST_NONE;
                face_seen = 1'b0;
            end
            OP_TICK: begin
                tx = int'(target_x);
                ty = int'(target_y);
                len2 = tx * tx + ty * ty;
                r.command = CMD_NONE;
                if (len2 < int'(dead_zone)) begin
                    r.command = CMD_STOP;
                    r.wait_units = stop_units;
                end else begin
                    r.wait_units = move_units;
                    if (tx * tx > ty * ty) begin
                        if (tx < 0) begin
                            r.command = CMD_LEFT;
                            target_x = target_x + 9'sd1;
                        end else if (tx > 0) begin
                            r.command = CMD_RIGHT;
                            target_x = target_x - 9'sd1;
                        end
                    end else begin
                        if (ty > 0) begin
                            r.command = CMD_DOWN;
                            target_y = target_y - 9'sd1;
                        end else if (ty < 0) begin
                            r.command = CMD_UP;
                            target_y = target_y + 9'sd1;
                        end
                    end
                end
                r.remaining_x = target_x;
                r.remaining_y = target_y;
                expected_commands.push_back(r);
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : predict
        t_item it;
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_index)
                REG_DEAD_ZONE: dead_zone = i_cfg_data;
                REG_STOP_WAIT: stop_units = i_cfg_data[7:0];
                REG_MOVE_WAIT: move_units = i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            it.opcode = s_axis_tuser;
            it.face_x = s_axis_tdata[7:0];
            it.face_y = s_axis_tdata[15:8];
            it.face_width = s_axis_tdata[24:16];
            it.face_height = s_axis_tdata[33:25];
            track_item(it);
        end
    end

    always @(posedge i_clk) begin : check_commands
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.command = m_axis_tdata[5:0];
            got.wait_units = m_axis_tdata[13:6];
            got.remaining_x = m_axis_tdata[22:14];
            got.remaining_y = m_axis_tdata[31:23];
            if (expected_commands.size() == 0) begin
                $error("command %0d arrived with no tick pending", got.command);
                failures++;
            end else begin
                want = expected_commands.pop_front();
                if (got.command !== want.command) begin
                    $error("command: expected %0d, got %0d", want.command, got.command);
                    failures++;
                end
                if (got.wait_units !== want.wait_units) begin
                    $error("wait_units: expected %0d, got %0d",
                           want.wait_units, got.wait_units);
                    failures++;
                end
                if (got.remaining_x !== want.remaining_x) begin
                    $error("remaining_x: expected %0d, got %0d",
                           want.remaining_x, got.remaining_x);
                    failures++;
                end
                if (got.remaining_y !== want.remaining_y) begin
                    $error("remaining_y: expected %0d, got %0d",
                           want.remaining_y, got.remaining_y);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 34);
    end

    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL pan_tilt_target_stepper");
                $finish;
            end
        end
    end

    task automatic send_item(t_item it);
        int gap;
        gap = 0;
        while (!quiet && gap < 20 && $urandom_range(99) < 34) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.opcode;
        s_axis_tdata <= {6'b0, it.face_height, it.face_width, it.face_y, it.face_x};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_face(int x, int y, int w, int h);
        t_item it;
        it.opcode = OP_FACE;
        it.face_x = x[7:0];
        it.face_y = y[7:0];
        it.face_width = w[8:0];
        it.face_height = h[8:0];
        send_item(it);
    endtask

    // Non-face items carry random rectangle bits, which the block must ignore.
    task automatic send_op(logic [1:0] op);
        t_item it;
        it.opcode = op;
        it.face_x = 8'($urandom);
        it.face_y = 8'($urandom);
        it.face_width = 9'($urandom);
        it.face_height = 9'($urandom);
        send_item(it);
    endtask

    task automatic send_random_face();
        int w;
        int h;
        if ($urandom_range(1) == 1) begin
            send_face($urandom_range(255), $urandom_range(255),
                      $urandom_range(511), $urandom_range(511));
        end else begin
            w = $urandom_range(256);
            h = $urandom_range(256);
            send_face(clamp_offset(HALF_FRAME - w / 2 + $urandom_range(60) - 30) & 8'hFF,
                      clamp_offset(HALF_FRAME - h / 2 + $urandom_range(60) - 30) & 8'hFF,
                      w, h);
        end
    endtask

    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_commands.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_registers(logic [15:0] zone, logic [7:0] stop_w, logic [7:0] move_w);
        settle_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_DEAD_ZONE;
        i_cfg_data <= zone;
        @(posedge i_clk);
        i_cfg_index <= REG_STOP_WAIT;
        i_cfg_data <= {8'b0, stop_w};
        @(posedge i_clk);
        i_cfg_index <= REG_MOVE_WAIT;
        i_cfg_data <= {8'b0, move_w};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_op(OP_TICK);
    endtask

    task automatic test_face_extremes();
        send_face(0, 0, 0, 0);
        send_face(255, 255, 511, 511);
        send_face(0, 255, 511, 0);
        send_op(OP_EOF);
        send_op(OP_TICK);
        send_op(OP_TICK);
    endtask

    task automatic test_ties_and_empty_frames();
        send_face(60, 128, 0, 0);
        send_face(196, 128, 0, 0);
        send_op(OP_EOF);
        send_op(OP_TICK);
        send_op(OP_EOF);
        send_op(OP_TICK);
        send_face(120, 120, 16, 16);
        send_op(OP_EOF);
        send_op(OP_TICK);
    endtask

    task automatic test_unused_opcode();
        send_op(OP_UNUSED);
        send_op(OP_UNUSED);
        send_op(OP_TICK);
    endtask

    task automatic test_zero_dead_zone();
        set_registers(16'd0, 8'd255, 8'd0);
        send_face(128, 128, 0, 0);
        send_op(OP_EOF);
        send_op(OP_TICK);
        send_face(128, 200, 0, 0);
        send_op(OP_EOF);
        send_op(OP_TICK);
        send_face(200, 128, 0, 0);
        send_op(OP_EOF);
        send_op(OP_TICK);
    endtask

    // Mostly whole frames followed by tick runs, with some stray items mixed in.
    task automatic run_tracking_phase(int item_budget);
        int sent;
        int faces;
        int ticks;
        t_item it;
        sent = 0;
        while (sent < item_budget) begin
            if ($urandom_range(99) < 80) begin
                faces = $urandom_range(4);
                repeat (faces) send_random_face();
                send_op(OP_EOF);
                ticks = ($urandom_range(9) == 0) ? 40 : $urandom_range(1, 6);
                repeat (ticks) send_op(OP_TICK);
                sent += faces + 1 + ticks;
            end else begin
                it.opcode = 2'($urandom_range(3));
                it.face_x = 8'($urandom);
                it.face_y = 8'($urandom);
                it.face_width = 9'($urandom);
                it.face_height = 9'($urandom);
                send_item(it);
                if (it.opcode != OP_UNUSED) sent++;
            end
            if ($urandom_range(49) == 0) settle_idle();
        end
    endtask

    task automatic test_random_tracking();
        set_registers(DEAD_ZONE_RESET, STOP_WAIT_RESET, MOVE_WAIT_RESET);
        run_tracking_phase(100);
        settle_idle();
        quiet = 1'b1;
        run_tracking_phase(80);
        settle_idle();
        quiet = 1'b0;
        set_registers(16'd0, 8'd255, 8'd0);
        run_tracking_phase(60);
        set_registers(16'hFFFF, 8'd0, 8'd255);
        run_tracking_phase(60);
        set_registers(16'($urandom_range(4000)), 8'($urandom), 8'($urandom));
        run_tracking_phase(100);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_face_extremes();
        test_ties_and_empty_frames();
        test_unused_opcode();
        test_zero_dead_zone();
        test_random_tracking();
        settle_idle();
        if (failures == 0) begin
            $display("PASS pan_tilt_target_stepper");
        end else begin
            $display("FAIL pan_tilt_target_stepper");
        end
        $finish;
    end

endmodule

`default_nettype wire
